FILE: hdl/vlfg_pkg.sv
`timescale 1ns / 1ps
// Shared sizes, word types, controller states and control structs for the voxel line fill grid.
// Depends on nothing; every other file of the block imports it.
package vlfg_pkg;

   localparam int AXIS_CELLS      = 16;
   localparam int COORD_FRAC_BITS = 8;
   localparam int VALUE_BITS      = 16;

   localparam int POS_W       = 16;
   localparam int CELL_OUT_W  = 8;
   localparam int READ_W      = 16;
   localparam int SIZE_REG_W  = 5;
   localparam int STORE_DEPTH = AXIS_CELLS * AXIS_CELLS * AXIS_CELLS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = $clog2(AXIS_CELLS);
   localparam int SZ_W        = $clog2(AXIS_CELLS + 1);
   localparam int CW          = (POS_W - COORD_FRAC_BITS + 2 > IDX_W + 2) ?
                                (POS_W - COORD_FRAC_BITS + 2) : (IDX_W + 2);
   localparam int MAX_WALK    = 3 * (AXIS_CELLS - 1) + 1;
   localparam int WALK_CNT_W  = $clog2(MAX_WALK);
   localparam int AD_W        = POS_W;
   localparam int N_W         = COORD_FRAC_BITS + $clog2(MAX_WALK + 2);
   localparam int NCALC_W     = CW + COORD_FRAC_BITS + 2;
   localparam int PROD_W      = N_W + AD_W;
   localparam int T_W         = PROD_W + 1;
   localparam int MUL_STEPS   = 6;
   localparam int MUL_CNT_W   = $clog2(MUL_STEPS + 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = CSR_IDX_W'(2);
   localparam logic [SIZE_REG_W-1:0] SIZE_RESET = SIZE_REG_W'(16);

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FILL  = 2'd2;

   typedef logic signed [CW-1:0] cell_type;
   typedef logic [SZ_W-1:0]      size_type;

   typedef struct packed {
      logic [1:0]              operation;
      logic signed [POS_W-1:0] start_x;
      logic signed [POS_W-1:0] start_y;
      logic signed [POS_W-1:0] start_z;
      logic signed [POS_W-1:0] end_x;
      logic signed [POS_W-1:0] end_y;
      logic signed [POS_W-1:0] end_z;
      logic [15:0]             value;
   } req_type;

   typedef struct packed {
      logic signed [CELL_OUT_W-1:0] cell_x;
      logic signed [CELL_OUT_W-1:0] cell_y;
      logic signed [CELL_OUT_W-1:0] cell_z;
      logic                         inside_res;
      logic [READ_W-1:0]            read_value;
      logic                         last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SINGLE,
      ST_MUL,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic rd_en;
      logic single_emit;
      logic mul;
      logic walk_emit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       start_inside;
      logic       mul_done;
      logic       out_free;
      logic       walk_last;
      logic       clear_last;
   } status_type;

endpackage

FILE: hdl/vlfg_ctrl.sv
`timescale 1ns / 1ps
// Controller of the voxel line fill grid: store clearing, decode, multiply setup and walk sequencing.
// Depends on vlfg_pkg; drives the datapath through cmd_type and reads status_type.
module vlfg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output vlfg_pkg::cmd_type    cmd,
   input  vlfg_pkg::status_type status
);
   import vlfg_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               OP_READ, OP_WRITE: state_in = ST_SINGLE;
               OP_FILL:           state_in = status.start_inside ? ST_MUL : ST_IDLE;
               default:           state_in = ST_IDLE;
            endcase
         end
         ST_SINGLE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            if (status.mul_done) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.out_free && status.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DECODE: begin
            cmd.prep  = 1'b1;
            cmd.rd_en = (status.op == OP_READ);
         end
         ST_SINGLE: cmd.single_emit = status.out_free;
         ST_MUL:    cmd.mul = 1'b1;
         ST_WALK:   cmd.walk_emit = status.out_free;
         default: ;
      endcase
   end

endmodule

FILE: hdl/vlfg_datapath.sv
`timescale 1ns / 1ps
// Datapath of the voxel line fill grid: size registers, cell store, DDA step logic, result register.
// Depends on vlfg_pkg; commanded by vlfg_ctrl.
module vlfg_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  vlfg_pkg::req_type                req_data,
   output vlfg_pkg::rsp_type                rsp_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             csr_write,
   input  logic [vlfg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vlfg_pkg::SIZE_REG_W-1:0]  csr_data,
   input  vlfg_pkg::cmd_type                cmd,
   output vlfg_pkg::status_type             status
);
   import vlfg_pkg::*;

   function automatic cell_type pos_cell(input logic signed [POS_W-1:0] p);
      logic signed [POS_W-1:0] sh;
      logic                    frac_nz;
      sh       = p >>> COORD_FRAC_BITS;
      frac_nz  = |p[COORD_FRAC_BITS-1:0];
      pos_cell = CW'(sh) + ((p[POS_W-1] && frac_nz) ? CW'(1) : CW'(0));
   endfunction

   function automatic size_type eff_size(input logic [SIZE_REG_W-1:0] r);
      eff_size = (r > AXIS_CELLS) ? SZ_W'(AXIS_CELLS) : SZ_W'(r);
   endfunction

   function automatic logic cell_inside(input cell_type c, input size_type s);
      logic signed [CW:0] cs;
      logic signed [CW:0] ss;
      cs          = (CW + 1)'(c);
      ss          = (CW + 1)'(s);
      cell_inside = (cs >= 0) && (cs < ss);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input cell_type x, input cell_type y,
                                                   input cell_type z);
      logic [ADDR_W-1:0] ax;
      logic [ADDR_W-1:0] ay;
      logic [ADDR_W-1:0] az;
      ax        = ADDR_W'(x[IDX_W-1:0]);
      ay        = ADDR_W'(y[IDX_W-1:0]);
      az        = ADDR_W'(z[IDX_W-1:0]);
      cell_addr = ax * ADDR_W'(AXIS_CELLS * AXIS_CELLS) + ay * ADDR_W'(AXIS_CELLS) + az;
   endfunction

   function automatic logic [N_W-1:0] init_n(input logic signed [POS_W-1:0] p,
                                             input cell_type c, input logic pos_dir);
      logic signed [NCALC_W-1:0] base;
      logic signed [NCALC_W-1:0] pe;
      logic signed [NCALC_W-1:0] nv;
      base = NCALC_W'(c) <<< COORD_FRAC_BITS;
      pe   = NCALC_W'(p);
      nv   = pos_dir ? (base + (NCALC_W'(1) <<< COORD_FRAC_BITS) - pe) : (pe - base);
      init_n = (nv < 0) ? '0 : N_W'(nv);
   endfunction

   req_type                 req_ff;
   logic [SIZE_REG_W-1:0]   size_ff [3];
   size_type                eff [3];
   logic signed [POS_W-1:0] sp [3];
   logic signed [POS_W-1:0] ep [3];
   logic signed [POS_W:0]   dlt [3];
   cell_type                start_c [3];
   cell_type                end_c [3];
   cell_type                cur_ff [3];
   cell_type                cur_in [3];
   cell_type                end_ff [3];
   logic [AD_W-1:0]         ad_ff [3];
   logic                    dirp_ff [3];
   logic [N_W-1:0]          n_ff [3];
   logic                    has [3];
   logic signed [T_W-1:0]   inc [3];
   logic signed [T_W-1:0]   txy_ff;
   logic signed [T_W-1:0]   txz_ff;
   logic signed [T_W-1:0]   tyz_ff;
   logic signed [T_W-1:0]   prod_ext;
   logic [PROD_W-1:0]       prod_ff;
   logic [N_W-1:0]          mul_n;
   logic [AD_W-1:0]         mul_ad;
   logic [MUL_CNT_W-1:0]    mul_cnt_ff;
   logic [WALK_CNT_W-1:0]   vcnt_ff;
   logic [ADDR_W-1:0]       clr_addr_ff;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ADDR_W-1:0]       rd_addr;
   logic [VALUE_BITS-1:0]   mem [STORE_DEPTH];
   logic [VALUE_BITS-1:0]   rd_data_ff;
   logic [VALUE_BITS-1:0]   wr_data;
   logic                    wr_en;
   logic                    inside_ff;
   logic                    start_inside;
   logic                    cur_inside;
   logic                    nxt_inside;
   logic                    at_end;
   logic                    y_win;
   logic                    x_keep;
   logic                    z_win;
   logic [2:0]              step;
   logic                    walk_last;
   logic                    advance;
   logic                    out_free;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= SIZE_RESET;
         size_ff[1] <= SIZE_RESET;
         size_ff[2] <= SIZE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SIZE_X: size_ff[0] <= csr_data;
            CSR_SIZE_Y: size_ff[1] <= csr_data;
            CSR_SIZE_Z: size_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      sp[0] = req_ff.start_x;
      sp[1] = req_ff.start_y;
      sp[2] = req_ff.start_z;
      ep[0] = req_ff.end_x;
      ep[1] = req_ff.end_y;
      ep[2] = req_ff.end_z;
      for (int i = 0; i < 3; i++) begin
         eff[i]     = eff_size(size_ff[i]);
         start_c[i] = pos_cell(sp[i]);
         end_c[i]   = pos_cell(ep[i]);
         dlt[i]     = (POS_W + 1)'(ep[i]) - (POS_W + 1)'(sp[i]);
         has[i]     = (ad_ff[i] != '0);
         inc[i]     = T_W'(ad_ff[i]) << COORD_FRAC_BITS;
      end
   end

   assign start_inside = cell_inside(start_c[0], eff[0]) && cell_inside(start_c[1], eff[1]) &&
                         cell_inside(start_c[2], eff[2]);
   assign cur_inside   = cell_inside(cur_ff[0], eff[0]) && cell_inside(cur_ff[1], eff[1]) &&
                         cell_inside(cur_ff[2], eff[2]);

   // nearest face; exact ties keep x, then y, then z
   always_comb begin
      y_win  = has[1] && (!has[0] || (txy_ff > 0));
      x_keep = has[0] && !y_win;
      z_win  = has[2] && ((!x_keep && !y_win) || (x_keep && (txz_ff > 0)) ||
                          (y_win && (tyz_ff > 0)));
      step   = {z_win, y_win && !z_win, x_keep && !z_win};
      for (int i = 0; i < 3; i++) begin
         if (step[i]) begin
            cur_in[i] = dirp_ff[i] ? (cur_ff[i] + CW'(1)) : (cur_ff[i] - CW'(1));
         end else begin
            cur_in[i] = cur_ff[i];
         end
      end
   end

   assign nxt_inside = cell_inside(cur_in[0], eff[0]) && cell_inside(cur_in[1], eff[1]) &&
                       cell_inside(cur_in[2], eff[2]);
   assign at_end     = (cur_ff[0] == end_ff[0]) && (cur_ff[1] == end_ff[1]) &&
                       (cur_ff[2] == end_ff[2]);
   assign walk_last  = at_end || (step == 3'b000) || !nxt_inside ||
                       (vcnt_ff == WALK_CNT_W'(MAX_WALK - 1));
   assign advance    = cmd.walk_emit && !walk_last;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         for (int i = 0; i < 3; i++) begin
            end_ff[i]  <= end_c[i];
            dirp_ff[i] <= (dlt[i] > 0);
            ad_ff[i]   <= dlt[i][POS_W] ? AD_W'(-dlt[i]) : AD_W'(dlt[i]);
            n_ff[i]    <= init_n(sp[i], start_c[i], dlt[i] > 0);
         end
         inside_ff <= start_inside;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff[0] <= '0;
         cur_ff[1] <= '0;
         cur_ff[2] <= '0;
      end else if (cmd.prep) begin
         cur_ff <= start_c;
      end else if (advance) begin
         cur_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff    <= '0;
         mul_cnt_ff <= '0;
      end else if (cmd.prep) begin
         vcnt_ff    <= '0;
         mul_cnt_ff <= '0;
      end else begin
         if (advance) begin
            vcnt_ff <= vcnt_ff + WALK_CNT_W'(1);
         end
         if (cmd.mul && (mul_cnt_ff != MUL_CNT_W'(MUL_STEPS))) begin
            mul_cnt_ff <= mul_cnt_ff + MUL_CNT_W'(1);
         end
      end
   end

   // one shared multiplier builds the three cross terms n_a*ad_b - n_b*ad_a
   always_comb begin
      case (mul_cnt_ff)
         MUL_CNT_W'(0): begin mul_n = n_ff[0]; mul_ad = ad_ff[1]; end
         MUL_CNT_W'(1): begin mul_n = n_ff[1]; mul_ad = ad_ff[0]; end
         MUL_CNT_W'(2): begin mul_n = n_ff[0]; mul_ad = ad_ff[2]; end
         MUL_CNT_W'(3): begin mul_n = n_ff[2]; mul_ad = ad_ff[0]; end
         MUL_CNT_W'(4): begin mul_n = n_ff[1]; mul_ad = ad_ff[2]; end
         MUL_CNT_W'(5): begin mul_n = n_ff[2]; mul_ad = ad_ff[1]; end
         default:       begin mul_n = '0;      mul_ad = '0;       end
      endcase
   end

   assign prod_ext = T_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PROD_W'(mul_n) * PROD_W'(mul_ad);
         case (mul_cnt_ff)
            MUL_CNT_W'(1): txy_ff <= prod_ext;
            MUL_CNT_W'(2): txy_ff <= txy_ff - prod_ext;
            MUL_CNT_W'(3): txz_ff <= prod_ext;
            MUL_CNT_W'(4): txz_ff <= txz_ff - prod_ext;
            MUL_CNT_W'(5): tyz_ff <= prod_ext;
            MUL_CNT_W'(6): tyz_ff <= tyz_ff - prod_ext;
            default: ;
         endcase
      end else if (advance) begin
         if (step[0]) begin
            txy_ff <= txy_ff + inc[1];
            txz_ff <= txz_ff + inc[2];
         end else if (step[1]) begin
            txy_ff <= txy_ff - inc[0];
            tyz_ff <= tyz_ff + inc[2];
         end else begin
            txz_ff <= txz_ff - inc[0];
            tyz_ff <= tyz_ff - inc[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   assign rd_addr = cell_addr(start_c[0], start_c[1], start_c[2]);
   assign wr_addr = cmd.clear ? clr_addr_ff : cell_addr(cur_ff[0], cur_ff[1], cur_ff[2]);
   assign wr_data = cmd.clear ? '0 : VALUE_BITS'(req_ff.value);
   assign wr_en   = cmd.clear || cmd.walk_emit ||
                    (cmd.single_emit && (req_ff.operation == OP_WRITE) && inside_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in.cell_x     = CELL_OUT_W'(cur_ff[0]);
      rsp_in.cell_y     = CELL_OUT_W'(cur_ff[1]);
      rsp_in.cell_z     = CELL_OUT_W'(cur_ff[2]);
      rsp_in.inside_res = inside_ff;
      rsp_in.read_value = (cmd.single_emit && (req_ff.operation == OP_READ) && inside_ff) ?
                          READ_W'(rd_data_ff) : '0;
      rsp_in.last       = cmd.walk_emit ? walk_last : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.single_emit || cmd.walk_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.single_emit || cmd.walk_emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status.op           = req_ff.operation;
      status.start_inside = start_inside;
      status.mul_done     = (mul_cnt_ff == MUL_CNT_W'(MUL_STEPS));
      status.out_free     = out_free;
      status.walk_last    = walk_last;
      status.clear_last   = (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1));
   end

   walk_in_grid: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_emit |-> cur_inside)
      else $error("walk writes a cell outside the grid");

   walk_one_axis: assert property (@(posedge clock) disable iff (reset)
      advance |=> $countones({cur_ff[0] != $past(cur_ff[0]), cur_ff[1] != $past(cur_ff[1]),
                              cur_ff[2] != $past(cur_ff[2])}) == 1)
      else $error("walk step moved other than one axis");

   walk_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_emit |-> (vcnt_ff < WALK_CNT_W'(MAX_WALK)))
      else $error("walk exceeds its voxel bound");

   clear_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !rsp_valid_ff)
      else $error("result pending during store clear");

endmodule

FILE: hdl/voxel_line_fill_grid_core.sv
`timescale 1ns / 1ps
// Top level of the voxel line fill grid: joins controller and datapath to the ports.
// Depends on vlfg_pkg, vlfg_ctrl and vlfg_datapath.
//
// Usage:
//   req_*  carries one command word (read cell, write cell, fill line) with Q8.8 positions.
//   rsp_*  returns result words; a fill returns one word per voxel written, and the
//          final word of every command has last set. Operation 3 returns nothing.
//   csr_*  writes the size_x/size_y/size_z registers; always ready, one write a cycle.
// Timing:
//   read and write pass through a decode state and a single emit state; the result word is registered.
//   a fill passes a decode state, then the shared cross-term multiplier, then writes one
//   voxel per cycle through the store write port while the output register is free.
//   A fill whose start cell is outside returns nothing after decode.
// Reset:
//   sizes return to 16 and a clearing pass zeroes the 4096-word store, one word a cycle;
//   req_ready stays low until the clearing pass is done.
// Stall:
//   a single output register holds the pending word; while rsp_ready is low the walk
//   holds its voxel and resumes when the word is taken.
module voxel_line_fill_grid_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  vlfg_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output vlfg_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vlfg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vlfg_pkg::SIZE_REG_W-1:0]  csr_data
);
   import vlfg_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   vlfg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   vlfg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
